>>> rtl/core/pbrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch decoder package
// Shared constants, the parse phase type and the base64 digit decoder.
// ----------------------------------------------------------------------------
package pbrle_pkg;

   // Default width of the decimal run counter.
   localparam int COUNT_WIDTH_DEF = 16;

   // Fixed field widths.
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 6;
   localparam int PITCH_W   = 12;
   localparam int REPEAT_W  = 16;
   localparam int SAMPLE_W  = 16;
   localparam int RSP_DATA_W = 32;

   // Reset value of the sample limit.
   localparam logic [SAMPLE_W-1:0] MAX_SAMPLES_RST = '1;

   // Character codes with a meaning of their own.
   localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPA   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPZ   = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWA  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWZ  = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

   // Base64 digit offsets.
   localparam logic [DIGIT_W-1:0] DIGIT_LOW_BASE = 6'd26;
   localparam logic [DIGIT_W-1:0] DIGIT_NUM_BASE = 6'd52;
   localparam logic [DIGIT_W-1:0] DIGIT_PLUS     = 6'd62;
   localparam logic [DIGIT_W-1:0] DIGIT_SLASH    = 6'd63;

   // Parse phase of the string decoder.
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,  // expecting the first digit of a pair
      PH_SECOND = 2'd1,  // expecting the second digit of a pair
      PH_DIGITS = 2'd2,  // reading the decimal run count
      PH_TAIL   = 2'd3   // count ended, waiting for the closing hash
   } phase_type;

   // Maps a byte through the base64 alphabet; other bytes give zero.
   function automatic logic [DIGIT_W-1:0] b64_digit(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] offs;
      logic [DIGIT_W-1:0] digit;
      offs  = '0;
      digit = '0;
      unique case (c) inside
         [CHAR_UPA:CHAR_UPZ]: begin
            offs  = c - CHAR_UPA;
            digit = offs[DIGIT_W-1:0];
         end
         [CHAR_LOWA:CHAR_LOWZ]: begin
            offs  = c - CHAR_LOWA;
            digit = offs[DIGIT_W-1:0] + DIGIT_LOW_BASE;
         end
         [CHAR_ZERO:CHAR_NINE]: begin
            offs  = c - CHAR_ZERO;
            digit = offs[DIGIT_W-1:0] + DIGIT_NUM_BASE;
         end
         CHAR_PLUS:  digit = DIGIT_PLUS;
         CHAR_SLASH: digit = DIGIT_SLASH;
         default:    digit = '0;
      endcase
      return digit;
   endfunction

endpackage

>>> rtl/core/pitch_bend_base64_rle_decoder.sv
`timescale 1ns / 1ps
// A character transferred on req is held in the input register, and its result, if
// any, in the result register. Throughput: one character per cycle while the result
// slot is free or drains; the input register and the result register let a new
// character enter while a finished result waits to be taken.
// Reset (synchronous, active high) clears the parse state and both stages and sets
// max_samples to 65535.
// ----------------------------------------------------------------------------
// Base64 run-length pitch decoder
// Decodes base64 character pairs into 12-bit pitch values and #N# runs into
// repeat counts, limited to a programmable number of samples per string.
// ----------------------------------------------------------------------------
module pitch_bend_base64_rle_decoder #(
   parameter int COUNT_WIDTH = pbrle_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Character stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pbrle_pkg::CHAR_W-1:0]        req_tdata,   // [7:0] char_code
   input  logic                                req_tlast,   // last_char
   // Decoded pitch stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pbrle_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [11:0] pitch_value,
                                                            // [27:12] repeat_count
   output logic                                rsp_tlast,   // end_flag
   // Sample limit register.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbrle_pkg::SAMPLE_W-1:0]      csr_wdata    // max_samples
);

   localparam int CW      = COUNT_WIDTH;
   localparam int PROD_W  = COUNT_WIDTH + 4;
   localparam int CMP_W   = (COUNT_WIDTH > pbrle_pkg::SAMPLE_W) ? COUNT_WIDTH
                                                                : pbrle_pkg::SAMPLE_W;
   localparam int PITCH_W = pbrle_pkg::PITCH_W;
   localparam int DIGIT_W = pbrle_pkg::DIGIT_W;
   localparam int SAMPLE_W = pbrle_pkg::SAMPLE_W;
   localparam int REPEAT_W = pbrle_pkg::REPEAT_W;

   // Configuration.
   logic [SAMPLE_W-1:0]      max_samples_ff;

   // Input register.
   logic                     in_valid_ff, in_valid_in;
   logic [pbrle_pkg::CHAR_W-1:0] in_char_ff;
   logic                     in_last_ff;

   // Parse state.
   pbrle_pkg::phase_type     phase_ff, phase_in;
   logic [DIGIT_W-1:0]       high_ff, high_in;
   logic [PITCH_W-1:0]       last_value_ff, last_value_in;
   logic [CW-1:0]            run_ff, run_in;
   logic [SAMPLE_W-1:0]      samples_ff, samples_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PITCH_W-1:0]       rsp_pitch_ff;
   logic [REPEAT_W-1:0]      rsp_repeat_ff;
   logic                     rsp_end_ff;

   // Datapath.
   logic                     advance;
   logic                     proc;
   logic                     is_hash;
   logic                     is_decimal;
   logic [DIGIT_W-1:0]       digit;
   logic [PROD_W-1:0]        run_next;
   logic [CW-1:0]            run_sat;
   logic                     do_emit;
   logic [CW-1:0]            want;
   logic [PITCH_W-1:0]       emit_value;
   logic                     emit_end;
   logic [SAMPLE_W-1:0]      room;
   logic [CMP_W-1:0]         want_ext;
   logic [CMP_W-1:0]         room_ext;
   logic [CMP_W-1:0]         take_ext;
   logic [REPEAT_W-1:0]      take;
   logic                     produced;

   // Handshake: the input stage moves on whenever the result slot is free or drains.
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign proc        = in_valid_ff && advance;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign csr_ready   = 1'b1;

   // Character classification and the saturating decimal step.
   assign is_hash    = (in_char_ff == pbrle_pkg::CHAR_HASH);
   assign is_decimal = (in_char_ff >= pbrle_pkg::CHAR_ZERO) &&
                       (in_char_ff <= pbrle_pkg::CHAR_NINE);
   assign digit      = pbrle_pkg::b64_digit(in_char_ff);
   assign run_next   = PROD_W'({run_ff, 3'b000}) + PROD_W'({run_ff, 2'b00})
                       - PROD_W'({run_ff, 1'b0}) + PROD_W'(in_char_ff[3:0]);
   assign run_sat    = (run_next[PROD_W-1:CW] != '0) ? '1 : run_next[CW-1:0];

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      if (proc) begin
         unique case (phase_ff)
            pbrle_pkg::PH_FIRST:  phase_in = is_hash ? pbrle_pkg::PH_DIGITS
                                                     : pbrle_pkg::PH_SECOND;
            pbrle_pkg::PH_SECOND: phase_in = pbrle_pkg::PH_FIRST;
            pbrle_pkg::PH_DIGITS: begin
               if (is_hash) begin
                  phase_in = pbrle_pkg::PH_FIRST;
               end else if (!is_decimal) begin
                  phase_in = pbrle_pkg::PH_TAIL;
               end
            end
            pbrle_pkg::PH_TAIL:   phase_in = is_hash ? pbrle_pkg::PH_FIRST
                                                     : pbrle_pkg::PH_TAIL;
            default:              phase_in = pbrle_pkg::PH_FIRST;
         endcase
         if (in_last_ff) begin
            phase_in = pbrle_pkg::PH_FIRST;
         end
      end
   end

   // Data state and the wanted emission for each phase.
   always_comb begin
      high_in       = high_ff;
      last_value_in = last_value_ff;
      run_in        = run_ff;
      do_emit       = 1'b0;
      want          = '0;
      emit_value    = last_value_ff;
      emit_end      = in_last_ff;
      unique case (phase_ff)
         pbrle_pkg::PH_FIRST: begin
            if (is_hash) begin
               run_in  = '0;
               do_emit = in_last_ff;
            end else begin
               high_in    = digit;
               emit_value = {digit, {DIGIT_W{1'b0}}};
               want       = CW'(1);
               do_emit    = in_last_ff;
            end
         end
         pbrle_pkg::PH_SECOND: begin
            last_value_in = {high_ff, digit};
            emit_value    = {high_ff, digit};
            want          = CW'(1);
            do_emit       = 1'b1;
         end
         default: begin
            if (is_hash) begin
               want    = run_ff;
               do_emit = 1'b1;
            end else begin
               if (phase_ff == pbrle_pkg::PH_DIGITS && is_decimal) begin
                  run_in = run_sat;
               end
               want    = run_in;
               do_emit = in_last_ff;
            end
         end
      endcase
   end

   // Clip the wanted repeat to the room left under the limit.
   assign room     = (max_samples_ff > samples_ff) ? (max_samples_ff - samples_ff) : '0;
   assign want_ext = CMP_W'(want);
   assign room_ext = CMP_W'(room);
   assign take_ext = (want_ext < room_ext) ? want_ext : room_ext;
   assign take     = take_ext[REPEAT_W-1:0];
   assign produced = proc && do_emit && (take != '0);

   always_comb begin
      samples_in = samples_ff;
      if (produced) begin
         samples_in = samples_ff + SAMPLE_W'(take);
      end
   end

   // Result slot holds until taken; a new result replaces a drained one.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (produced) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_samples_ff <= pbrle_pkg::MAX_SAMPLES_RST;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= pbrle_pkg::PH_FIRST;
         high_ff        <= '0;
         last_value_ff  <= '0;
         run_ff         <= '0;
         samples_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_samples_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         if (proc) begin
            if (in_last_ff) begin
               high_ff       <= '0;
               last_value_ff <= '0;
               run_ff        <= '0;
               samples_ff    <= '0;
            end else begin
               high_ff       <= high_in;
               last_value_ff <= last_value_in;
               run_ff        <= run_in;
               samples_ff    <= samples_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (produced) begin
         rsp_pitch_ff  <= emit_value;
         rsp_repeat_ff <= take;
         rsp_end_ff    <= emit_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pbrle_pkg::RSP_DATA_W - PITCH_W - REPEAT_W){1'b0}},
                        rsp_repeat_ff, rsp_pitch_ff};
   assign rsp_tlast  = rsp_end_ff;

`ifndef NO_ASSERTIONS
   // A delivered result always carries at least one sample.
   a_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_repeat_ff != '0))
      else $error("result with zero repeat count");

   // A produced result occupies the result slot in the next cycle.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      produced |=> rsp_valid_ff)
      else $error("produced result not held in the result register");

   // The end of a string returns the parser to its start.
   a_string_end: assert property (@(posedge clock) disable iff (reset)
      (proc && in_last_ff) |=> (phase_ff == pbrle_pkg::PH_FIRST && samples_ff == '0))
      else $error("parser state not cleared after the final character");

   // A result is only produced when the slot can take it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      produced |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrites one not yet transferred");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the base64 run-length pitch decoder
// Streams encoded pitch strings into the decoder and predicts every decoded
// sample alongside it. Each pitch value, repeat count and end flag is compared with
// the prediction. The run covers directed strings, sample limit settings,
// a long output stall and randomized strings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import pbrle_pkg::*;

   localparam int          RUN_W        = COUNT_WIDTH_DEF;
   localparam int unsigned RUN_SAT      = (1 << RUN_W) - 1;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          RANDOM_CHARS = 1600;
   localparam int          CYCLE_LIMIT  = 500000;

   // One decoded sample run as the decoder should deliver it.
   typedef struct packed {
      logic [PITCH_W-1:0]  pitch;
      logic [REPEAT_W-1:0] repeats;
      logic                ends;
   } pitch_sample_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [SAMPLE_W-1:0]   csr_wdata  = '0;

   // Predicted decoder state.
   phase_type             parse_ph;
   logic [DIGIT_W-1:0]    hi_dig;
   logic [PITCH_W-1:0]    prev_pitch;
   int unsigned           run_total;
   logic [SAMPLE_W-1:0]   samples_done;
   logic [SAMPLE_W-1:0]   sample_limit;

   pitch_sample_type      expected_pitches[$];

   int unsigned           error_count    = 0;
   int unsigned           chars_sent     = 0;
   int unsigned           results_seen   = 0;
   int unsigned           limit_writes   = 0;
   int unsigned           cycle_count    = 0;
   int unsigned           stall_left     = 0;
   int unsigned           rsp_wait       = 0;
   bit                    sender_idles   = 1'b1;
   bit                    receiver_idles = 1'b1;

   pitch_bend_base64_rle_decoder #(
      .COUNT_WIDTH(RUN_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] char_code
      .req_tlast  (req_tlast),    // last_char
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [11:0] pitch_value, [27:12] repeat_count
      .rsp_tlast  (rsp_tlast),    // end_flag
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)     // max_samples
   );

   always #6 clock = ~clock;

   // Free-running cycle count for the watchdog and the summary.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_top: timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_pitches.size());
      $display("tb_top: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Clears the predicted string state, as the end of a string does.
   function automatic void clear_string();
      parse_ph     = PH_FIRST;
      hi_dig       = '0;
      prev_pitch   = '0;
      run_total    = 0;
      samples_done = '0;
   endfunction

   // Maps a byte through the base64 alphabet; anything else is zero.
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] offs;
      offs = '0;
      if (c >= CHAR_UPA && c <= CHAR_UPZ) begin
         offs = c - CHAR_UPA;
      end else if (c >= CHAR_LOWA && c <= CHAR_LOWZ) begin
         offs = c - CHAR_LOWA + CHAR_W'(DIGIT_LOW_BASE);
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         offs = c - CHAR_ZERO + CHAR_W'(DIGIT_NUM_BASE);
      end else if (c == CHAR_PLUS) begin
         offs = CHAR_W'(DIGIT_PLUS);
      end else if (c == CHAR_SLASH) begin
         offs = CHAR_W'(DIGIT_SLASH);
      end
      return offs[DIGIT_W-1:0];
   endfunction

   // Queues a sample run, clipped to the room left under the limit.
   function automatic void add_samples(input logic [PITCH_W-1:0] value,
                                       input int unsigned wanted, input logic ends);
      int unsigned      room;
      int unsigned      n;
      pitch_sample_type s;
      room = (sample_limit > samples_done) ? sample_limit - samples_done : 0;
      n    = (wanted < room) ? wanted : room;
      if (n != 0) begin
         samples_done = samples_done + SAMPLE_W'(n);
         s.pitch      = value;
         s.repeats    = REPEAT_W'(n);
         s.ends       = ends;
         expected_pitches.push_back(s);
      end
   endfunction

   // Advances the predicted decoder by one transferred character.
   function automatic void decode_char(input logic [CHAR_W-1:0] c, input logic is_last);
      case (parse_ph)
         PH_FIRST: begin
            if (c == CHAR_HASH) begin
               run_total = 0;
               parse_ph  = PH_DIGITS;
               if (is_last) add_samples(prev_pitch, run_total, 1'b1);
            end else begin
               hi_dig   = digit_of(c);
               parse_ph = PH_SECOND;
               if (is_last) begin
                  // A half pair takes zero for the missing digit.
                  prev_pitch = {hi_dig, {DIGIT_W{1'b0}}};
                  add_samples(prev_pitch, 1, 1'b1);
               end
            end
         end
         PH_SECOND: begin
            prev_pitch = {hi_dig, digit_of(c)};
            parse_ph   = PH_FIRST;
            add_samples(prev_pitch, 1, is_last);
         end
         default: begin
            if (c == CHAR_HASH) begin
               add_samples(prev_pitch, run_total, is_last);
               parse_ph = PH_FIRST;
            end else begin
               // Only leading decimal digits count; the count saturates.
               if (parse_ph == PH_DIGITS) begin
                  if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                     run_total = run_total * 10 + (c - CHAR_ZERO);
                     if (run_total > RUN_SAT) run_total = RUN_SAT;
                  end else begin
                     parse_ph = PH_TAIL;
                  end
               end
               // A run still open at the last byte is emitted as if closed.
               if (is_last) add_samples(prev_pitch, run_total, 1'b1);
            end
         end
      endcase
      if (is_last) clear_string();
   endfunction

   // Receiver side: random hold-offs per result, plus a long stall on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait = receiver_idles ? $urandom_range(0, 10) : 0;
         rsp_tready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait = rsp_wait - 1;
         rsp_tready <= (rsp_wait == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares each transferred result with the oldest prediction.
   always @(posedge clock) begin : check_results
      pitch_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_pitches.size() == 0) begin
            report_mismatch($sformatf("unexpected result, data %h end %b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = expected_pitches.pop_front();
            if (rsp_tdata[PITCH_W-1:0] !== want.pitch)
               report_mismatch($sformatf("pitch %0d, expected %0d",
                                         $signed(rsp_tdata[PITCH_W-1:0]),
                                         $signed(want.pitch)));
            if (rsp_tdata[PITCH_W +: REPEAT_W] !== want.repeats)
               report_mismatch($sformatf("repeat %0d, expected %0d",
                                         rsp_tdata[PITCH_W +: REPEAT_W], want.repeats));
            if (rsp_tlast !== want.ends)
               report_mismatch($sformatf("end flag %b, expected %b", rsp_tlast, want.ends));
         end
      end
   end

   // Sends one character and waits for its transfer.
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_last);
      int gap;
      gap = sender_idles ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      decode_char(c, is_last);
      chars_sent++;
   endtask

   task automatic send_text(input string text, input bit ends_string);
      for (int i = 0; i < text.len(); i++)
         send_char(text[i], ends_string && (i == text.len() - 1));
   endtask

   // Drops the character stream; only called right before time passes.
   task automatic stream_pause();
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_results();
      stream_pause();
      while (expected_pitches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the sample limit once the decoder has gone idle.
   task automatic write_limit(input logic [SAMPLE_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sample_limit = value;
      limit_writes++;
   endtask

   function automatic logic [CHAR_W-1:0] pick_b64_char();
      int unsigned idx;
      idx = $urandom_range(0, 63);
      if (idx < 26) return CHAR_UPA + CHAR_W'(idx);
      if (idx < 52) return CHAR_LOWA + CHAR_W'(idx - 26);
      if (idx < 62) return CHAR_ZERO + CHAR_W'(idx - 52);
      if (idx == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // Builds one random string, mostly well-formed pairs and runs, and sends it.
   task automatic send_random_string();
      logic [CHAR_W-1:0] text[$];
      string             numtext;
      int unsigned       n;
      int unsigned       pick;
      int                pieces;
      pieces = $urandom_range(1, 12);
      for (int p = 0; p < pieces; p++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            repeat (2) text.push_back(($urandom_range(0, 19) != 0) ? pick_b64_char()
                                                                   : CHAR_W'($urandom));
         end else if (pick < 75) begin
            text.push_back(CHAR_HASH);
            pick = $urandom_range(0, 99);
            if (pick < 65)      n = $urandom_range(0, 40);
            else if (pick < 85) n = $urandom_range(0, 999);
            else                n = $urandom_range(0, 999999);
            if ($urandom_range(0, 9) != 0) begin
               numtext = $sformatf("%0d", n);
               for (int i = 0; i < numtext.len(); i++) text.push_back(numtext[i]);
            end
            if ($urandom_range(0, 6) == 0)
               repeat ($urandom_range(1, 3)) text.push_back(CHAR_W'($urandom));
            if ($urandom_range(0, 9) != 0) text.push_back(CHAR_HASH);
         end else if (pick < 88) begin
            text.push_back(CHAR_W'($urandom_range(0, 255)));
         end else begin
            text.push_back(pick_b64_char());
         end
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_limit();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return SAMPLE_W'($urandom_range(1, 64));
         5, 6:    return SAMPLE_W'($urandom_range(65, 2000));
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Field extremes, every character class, runs with tails, saturation,
   // an empty run, a half pair and an unclosed run.
   task automatic test_directed_strings();
      send_text("gAf/", 0);
      send_text("+9z#", 0);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_text("#2x#", 0);
      send_text("##", 0);
      send_text("#99999#", 1);
      send_text("Q", 1);
      send_text("#4", 1);
   endtask

   // Zero limit, clipping, a limit lowered under the count mid-string and a
   // value decoded past the limit that a later run repeats.
   task automatic test_sample_limit();
      write_limit('0);
      send_text("AB#9#C", 1);
      write_limit(SAMPLE_W'(5));
      send_text("ABCD#9#EF", 1);
      write_limit(SAMPLE_W'(40));
      send_text("Zz#30#", 0);
      write_limit(SAMPLE_W'(20));
      send_text("Q9", 0);
      write_limit('1);
      send_text("#3#A", 1);
   endtask

   // The receiver holds off long enough for the decoder to stall its input.
   task automatic test_output_stall();
      drain_results();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      stall_left     = 250;
      for (int i = 0; i < 80; i++) send_char(pick_b64_char(), i == 79);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Random strings in phases, each with its own limit and idling mix.
   task automatic test_random_strings();
      int unsigned start;
      start = chars_sent;
      while (chars_sent - start < RANDOM_CHARS) begin
         write_limit(pick_limit());
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         repeat (8) send_random_string();
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   initial begin
      sample_limit = MAX_SAMPLES_RST;
      clear_string();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_strings();
      test_sample_limit();
      test_output_stall();
      test_random_strings();
      drain_results();

      $display("tb_top: %0d characters sent, %0d results checked, %0d limit writes",
               chars_sent, results_seen, limit_writes);
      $display("tb_top: %0d cycles, %0d mismatches", cycle_count, error_count);
      if (error_count == 0 && expected_pitches.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/pbrle_pkg.sv
rtl/core/pitch_bend_base64_rle_decoder.sv
sim/tb_top.sv
